### hdl/integer_to_roman_encoder_assert.svh
// Assertion macros for the Roman numeral encoder checker.
`ifndef INTEGER_TO_ROMAN_ENCODER_ASSERT_SVH
`define INTEGER_TO_ROMAN_ENCODER_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define RIE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rie assertion failed");

// Check a consequence in the cycle after its trigger.
`define RIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rie assertion failed");

`endif

### hdl/rie_pkg.sv
// Types, constants and letter tables of the Roman numeral encoder.
package rie_pkg;

   localparam int unsigned VALUE_W   = 12;
   localparam int unsigned SYMBOL_W  = 8;
   localparam int unsigned MAX_VALUE = 3999;
   localparam int unsigned MAX_CHARS = 15;
   localparam int unsigned RUN_CNT_W = $clog2(MAX_CHARS);

   localparam int unsigned THOUSAND  = 1000;
   localparam int unsigned HUNDRED   = 100;
   localparam int unsigned TEN       = 10;
   localparam int unsigned REM_TH_W  = 10;  // remainder below one thousand
   localparam int unsigned REM_H_W   = 7;   // remainder below one hundred
   localparam int unsigned REM_T_W   = 4;   // remainder below ten

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
   localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
   localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
   localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
   localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
   localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
   localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;
   localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;

   localparam logic [3:0] DIGIT_FOUR = 4'd4;
   localparam logic [3:0] DIGIT_FIVE = 4'd5;
   localparam logic [3:0] DIGIT_NINE = 4'd9;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic      out_of_range;
      logic [1:0] thousands;
      digit_type hundreds;
      digit_type tens;
      digit_type ones;
   } job_type;

   typedef enum logic [1:0] {
      POS_ONES,
      POS_TENS,
      POS_HUNDREDS,
      POS_THOUSANDS
   } pos_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

   // Number of letters a decimal digit takes in subtractive form.
   function automatic logic [2:0] digit_len(digit_type d);
      logic [2:0] len;
      unique case (d)
         4'd0:    len = 3'd0;
         4'd1:    len = 3'd1;
         4'd2:    len = 3'd2;
         4'd3:    len = 3'd3;
         4'd4:    len = 3'd2;
         4'd5:    len = 3'd1;
         4'd6:    len = 3'd2;
         4'd7:    len = 3'd3;
         4'd8:    len = 3'd4;
         4'd9:    len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [SYMBOL_W-1:0] unit_letter(pos_type pos);
      logic [SYMBOL_W-1:0] sym;
      unique case (pos)
         POS_ONES:      sym = SYM_I;
         POS_TENS:      sym = SYM_X;
         POS_HUNDREDS:  sym = SYM_C;
         POS_THOUSANDS: sym = SYM_M;
         default:       sym = SYM_NONE;
      endcase
      return sym;
   endfunction

   function automatic logic [SYMBOL_W-1:0] five_letter(pos_type pos);
      logic [SYMBOL_W-1:0] sym;
      unique case (pos)
         POS_ONES:     sym = SYM_V;
         POS_TENS:     sym = SYM_L;
         POS_HUNDREDS: sym = SYM_D;
         default:      sym = SYM_NONE;
      endcase
      return sym;
   endfunction

   function automatic logic [SYMBOL_W-1:0] ten_letter(pos_type pos);
      logic [SYMBOL_W-1:0] sym;
      unique case (pos)
         POS_ONES:     sym = SYM_X;
         POS_TENS:     sym = SYM_C;
         POS_HUNDREDS: sym = SYM_M;
         default:      sym = SYM_NONE;
      endcase
      return sym;
   endfunction

   // Letter number k of digit d written at position pos.
   function automatic logic [SYMBOL_W-1:0] digit_letter(pos_type pos, logic [1:0] k,
                                                        digit_type d);
      logic [SYMBOL_W-1:0] sym;
      priority if (d == DIGIT_NINE) begin
         sym = (k == 2'd0) ? unit_letter(pos) : ten_letter(pos);
      end else if (d == DIGIT_FOUR) begin
         sym = (k == 2'd0) ? unit_letter(pos) : five_letter(pos);
      end else if (d >= DIGIT_FIVE) begin
         sym = (k == 2'd0) ? five_letter(pos) : unit_letter(pos);
      end else begin
         sym = unit_letter(pos);
      end
      return sym;
   endfunction

   // Positions that hold a non-zero digit, one bit per position.
   function automatic logic [3:0] job_mask(job_type job);
      return {job.thousands != 2'd0, job.hundreds != 4'd0,
              job.tens != 4'd0, job.ones != 4'd0};
   endfunction

   // Highest position set in a mask.
   function automatic pos_type top_pos(logic [3:0] mask);
      pos_type pos;
      priority if (mask[3]) begin
         pos = POS_THOUSANDS;
      end else if (mask[2]) begin
         pos = POS_HUNDREDS;
      end else if (mask[1]) begin
         pos = POS_TENS;
      end else begin
         pos = POS_ONES;
      end
      return pos;
   endfunction

endpackage

### hdl/rie_if.sv
// Valid/ready channel interfaces for the encoder's request and response sides.
interface rie_req_if;
   import rie_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rie_rsp_if;
   import rie_pkg::*;

   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                last;
   logic                out_of_range;

   modport source (output valid, output symbol, output last, output out_of_range,
                   input ready);
   modport sink   (input valid, input symbol, input last, input out_of_range,
                   output ready);
endinterface

### hdl/rie_queue.sv
// Short job queue between the digit splitter and the letter sequencer.
module rie_queue (
   input  logic             clock,
   input  logic             reset,
   input  rie_pkg::job_type push_job,
   input  logic             push_valid,
   output logic             push_ready,
   output rie_pkg::job_type pop_job,
   output logic             pop_valid,
   input  logic             pop_ready
);
   import rie_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push_fire;
   logic                   pop_fire;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hdl/rie_front.sv
// Request stage: takes a value, range-checks it and splits it into decimal digits.
module rie_front (
   input  logic             clock,
   input  logic             reset,
   rie_req_if.sink          req_bus,
   output rie_pkg::job_type push_job,
   output logic             push_valid,
   input  logic             push_ready
);
   import rie_pkg::*;

   logic               hold_valid_ff, hold_valid_in;
   logic [VALUE_W-1:0] hold_value_ff;
   logic               req_fire;

   logic [1:0]          thousands;
   logic [VALUE_W-1:0]  sub_th;
   logic [REM_TH_W-1:0] rem_th;
   digit_type           hundreds;
   logic [REM_TH_W-1:0] sub_h;
   logic [REM_H_W-1:0]  rem_h;
   digit_type           tens;
   logic [REM_H_W-1:0]  sub_t;
   logic [REM_T_W-1:0]  rem_t;

   assign req_bus.ready = !hold_valid_ff || push_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign push_valid    = hold_valid_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_fire) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_value_ff <= req_bus.value;
      end
   end

   // Digit split by comparing against the multiples of each power of ten.
   always_comb begin
      thousands = '0;
      sub_th    = '0;
      for (int i = 1; i <= 3; i++) begin
         if (hold_value_ff >= VALUE_W'(i * THOUSAND)) begin
            thousands = 2'(i);
            sub_th    = VALUE_W'(i * THOUSAND);
         end
      end
      rem_th = REM_TH_W'(hold_value_ff - sub_th);

      hundreds = '0;
      sub_h    = '0;
      for (int i = 1; i <= 9; i++) begin
         if (rem_th >= REM_TH_W'(i * HUNDRED)) begin
            hundreds = 4'(i);
            sub_h    = REM_TH_W'(i * HUNDRED);
         end
      end
      rem_h = REM_H_W'(rem_th - sub_h);

      tens  = '0;
      sub_t = '0;
      for (int i = 1; i <= 9; i++) begin
         if (rem_h >= REM_H_W'(i * TEN)) begin
            tens  = 4'(i);
            sub_t = REM_H_W'(i * TEN);
         end
      end
      rem_t = REM_T_W'(rem_h - sub_t);
   end

   assign push_job.out_of_range = (hold_value_ff == '0) ||
                                  (hold_value_ff > VALUE_W'(MAX_VALUE));
   assign push_job.thousands    = thousands;
   assign push_job.hundreds     = hundreds;
   assign push_job.tens         = tens;
   assign push_job.ones         = rem_t;

endmodule

### hdl/rie_back.sv
// Letter sequencer: walks the digits of one job and sends one letter per transfer.
module rie_back (
   input  logic             clock,
   input  logic             reset,
   input  rie_pkg::job_type pop_job,
   input  logic             pop_valid,
   output logic             pop_ready,
   rie_rsp_if.source        rsp_bus
);
   import rie_pkg::*;

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   pos_type             pos_ff, pos_in;
   logic [1:0]          k_ff, k_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] rsp_symbol_ff;
   logic                rsp_last_ff;
   logic                rsp_oor_ff;

   logic                out_free;
   logic                emit;
   logic [SYMBOL_W-1:0] emit_symbol;
   logic                emit_last;
   logic                emit_oor;

   digit_type           cur_digit;
   logic [2:0]          cur_len;
   logic [3:0]          lower_mask;
   logic                digit_done;
   logic                last_char;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      unique case (pos_ff)
         POS_ONES:      cur_digit = job_ff.ones;
         POS_TENS:      cur_digit = job_ff.tens;
         POS_HUNDREDS:  cur_digit = job_ff.hundreds;
         POS_THOUSANDS: cur_digit = {2'b00, job_ff.thousands};
         default:       cur_digit = '0;
      endcase
   end

   assign cur_len    = digit_len(cur_digit);
   assign lower_mask = job_mask(job_ff) & 4'((4'b0001 << pos_ff) - 4'b0001);
   assign digit_done = ({1'b0, k_ff} == 3'(cur_len - 3'd1));
   assign last_char  = digit_done && (lower_mask == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid && out_free && !pop_job.out_of_range) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && last_char) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready   = 1'b0;
      emit        = 1'b0;
      emit_symbol = SYM_NONE;
      emit_last   = 1'b0;
      emit_oor    = 1'b0;
      job_in      = job_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = out_free;
            if (pop_valid && out_free) begin
               if (pop_job.out_of_range) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  emit_oor  = 1'b1;
               end else begin
                  job_in = pop_job;
                  pos_in = top_pos(job_mask(pop_job));
                  k_in   = '0;
               end
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_symbol = digit_letter(pos_ff, k_ff, cur_digit);
               emit_last   = last_char;
               if (digit_done) begin
                  pos_in = top_pos(lower_mask);
                  k_in   = '0;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pos_ff <= pos_in;
      k_ff   <= k_in;
      if (emit) begin
         rsp_symbol_ff <= emit_symbol;
         rsp_last_ff   <= emit_last;
         rsp_oor_ff    <= emit_oor;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.symbol       = rsp_symbol_ff;
   assign rsp_bus.last         = rsp_last_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

endmodule

### hdl/integer_to_roman_encoder.sv
// Top level of the integer to Roman numeral encoder.
//
// Each request transfer carries a 12-bit unsigned value. The block answers
// with its Roman numeral as a run of ASCII letters (I V X L C D M), one
// response transfer per letter, most significant letter first, with last
// set on the final letter. Thousands are written as repeated M, all other
// digits in subtractive form (IV, IX, XL, XC, CD, CM); the longest run is
// fifteen letters, for 3888. A value of 0 or above 3999 gives a single
// response with symbol 0, last set and out_of_range set. The front stage
// registers a value, splits it into digits and hands it over a two-entry
// queue to the letter sequencer, so a new request is taken while earlier
// letters still go out. The sequencer loads a value and then sends its
// letters in order; an out-of-range value is answered without a load.
// A response waits in an output register until it is taken.
module integer_to_roman_encoder (
   input logic       clock,
   input logic       reset,
   rie_req_if.sink   req_bus,
   rie_rsp_if.source rsp_bus
);
   import rie_pkg::*;

   // front to queue
   job_type push_job;
   logic    push_valid;
   logic    push_ready;

   // queue to sequencer
   job_type pop_job;
   logic    pop_valid;
   logic    pop_ready;

   // Range check and digit split; hold one value until the queue takes it.
   rie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_job   (push_job),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // Decouple the splitter from the sequencer.
   rie_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (push_job),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_job    (pop_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // Emit letters one transfer at a time from the current job.
   rie_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_job   (pop_job),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

### hdl/rie_checker.sv
// Port-level checker for the Roman numeral encoder and its bind.
`include "integer_to_roman_encoder_assert.svh"

module rie_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rie_pkg::SYMBOL_W-1:0] rsp_symbol,
   input logic                         rsp_last,
   input logic                         rsp_out_of_range
);
   import rie_pkg::*;

   logic [RUN_CNT_W-1:0] run_cnt_ff, run_cnt_in;
   logic                 rsp_fire;
   logic                 is_letter;
   logic                 err_alone;

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign is_letter = (rsp_symbol == SYM_I) || (rsp_symbol == SYM_V) ||
                      (rsp_symbol == SYM_X) || (rsp_symbol == SYM_L) ||
                      (rsp_symbol == SYM_C) || (rsp_symbol == SYM_D) ||
                      (rsp_symbol == SYM_M);
   assign err_alone = rsp_last && (rsp_symbol == SYM_NONE) && (run_cnt_ff == '0);

   // Count letters already sent in the current run.
   always_comb begin
      run_cnt_in = run_cnt_ff;
      if (rsp_fire) begin
         run_cnt_in = rsp_last ? '0 : run_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else begin
         run_cnt_ff <= run_cnt_in;
      end
   end

   `RIE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol) && $stable(rsp_last) && $stable(rsp_out_of_range))
   `RIE_ASSERT_NOW(a_err_alone, clock, reset, rsp_valid && rsp_out_of_range, err_alone)
   `RIE_ASSERT_NOW(a_letter, clock, reset, rsp_valid && !rsp_out_of_range, is_letter)
   `RIE_ASSERT_NOW(a_run_len, clock, reset, rsp_valid && !rsp_last, run_cnt_ff < RUN_CNT_W'(MAX_CHARS - 1))

endmodule

bind integer_to_roman_encoder rie_checker u_rie_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_symbol       (rsp_bus.symbol),
   .rsp_last         (rsp_bus.last),
   .rsp_out_of_range (rsp_bus.out_of_range)
);

### sim/tb_integer_to_roman_encoder.sv
// Self-checking testbench for the integer to Roman numeral encoder.
module tb_integer_to_roman_encoder;
   import rie_pkg::*;

   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Length of the forced response-side hold-off that backs up the block.
   localparam int unsigned LONG_HOLD = 200;
   // Quiet cycles allowed after the last expected letter has arrived.
   localparam int unsigned SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      logic                out_of_range;
   } letter_type;

   logic clock;
   logic reset;

   rie_req_if req_bus ();
   rie_rsp_if rsp_bus ();

   integer_to_roman_encoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Values waiting to be offered, and letters still owed by the block.
   logic [VALUE_W-1:0] pending_values[$];
   letter_type         expected_letters[$];

   int unsigned values_queued;
   int unsigned values_taken;
   int unsigned failures;
   int unsigned quiet_cycles;

   // Idling knobs, switched per phase by the stimulus process.
   bit          tx_gaps_on;
   bit          rx_stalls_on;
   int unsigned long_hold_requests;
   int unsigned long_holds_done;

   // Driver and receiver bookkeeping.
   bit          req_fired;
   int unsigned gap_left;
   int unsigned stall_left;

   // Free-running clock: four units high, four low.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Spell a value as Roman letters and append them to the expected queue.
   // Zero and anything above the top value give one flagged empty letter.
   function automatic void spell_roman(logic [VALUE_W-1:0] value);
      int unsigned         v;
      int unsigned         digit;
      int unsigned         scale;
      int unsigned         k;
      logic [SYMBOL_W-1:0] unit_sym;
      logic [SYMBOL_W-1:0] five_sym;
      logic [SYMBOL_W-1:0] ten_sym;
      logic [SYMBOL_W-1:0] run[$];
      letter_type          letter;
      v = value;
      if (v == 0 || v > MAX_VALUE) begin
         letter.symbol       = SYM_NONE;
         letter.last         = 1'b1;
         letter.out_of_range = 1'b1;
         expected_letters.push_back(letter);
         return;
      end
      for (k = 0; k < v / THOUSAND; k++) begin
         run.push_back(SYM_M);
      end
      for (scale = HUNDRED; scale != 0; scale = scale / TEN) begin
         case (scale)
            HUNDRED: begin
               unit_sym = SYM_C;
               five_sym = SYM_D;
               ten_sym  = SYM_M;
            end
            TEN: begin
               unit_sym = SYM_X;
               five_sym = SYM_L;
               ten_sym  = SYM_C;
            end
            default: begin
               unit_sym = SYM_I;
               five_sym = SYM_V;
               ten_sym  = SYM_X;
            end
         endcase
         digit = (v / scale) % TEN;
         if (digit == DIGIT_NINE) begin
            run.push_back(unit_sym);
            run.push_back(ten_sym);
         end else if (digit == DIGIT_FOUR) begin
            run.push_back(unit_sym);
            run.push_back(five_sym);
         end else begin
            if (digit >= DIGIT_FIVE) begin
               run.push_back(five_sym);
               digit = digit - DIGIT_FIVE;
            end
            for (k = 0; k < digit; k++) begin
               run.push_back(unit_sym);
            end
         end
      end
      foreach (run[i]) begin
         letter.symbol       = run[i];
         letter.last         = (i == run.size() - 1);
         letter.out_of_range = 1'b0;
         expected_letters.push_back(letter);
      end
   endfunction

   // Pick an idle stretch: mostly very short, sometimes somewhat longer, rarely long.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 2);
      end else if (r < 95) begin
         return $urandom_range(3, 6);
      end
      return $urandom_range(20, 60);
   endfunction

   // Random value, weighted toward short and long runs and the out-of-range cases.
   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return VALUE_W'($urandom_range(1, MAX_VALUE));
      end else if (r < 72) begin
         return VALUE_W'($urandom_range(1, 99));
      end else if (r < 84) begin
         return VALUE_W'($urandom_range(3000, MAX_VALUE));
      end else if (r < 90) begin
         return '0;
      end
      return VALUE_W'($urandom_range(MAX_VALUE + 1, (1 << VALUE_W) - 1));
   endfunction

   task automatic queue_value(logic [VALUE_W-1:0] value);
      pending_values.push_back(value);
      values_queued++;
   endtask

   // Hold until every queued value has been taken and all its letters seen.
   task automatic drain();
      while (values_taken != values_queued || expected_letters.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver: change the channel only at the falling edge. Hold the
   // offered value until the last rising edge took it, then either idle for
   // a random gap or advance to the next pending value.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fired) begin
         // hold: the current value has not been taken yet
      end else if (gap_left > 0) begin
         gap_left      = gap_left - 1;
         req_bus.valid <= 1'b0;
      end else if (pending_values.size() > 0) begin
         req_bus.valid <= 1'b1;
         req_bus.value <= pending_values.pop_front();
         gap_left      = (tx_gaps_on && $urandom_range(0, 99) < 40) ? idle_length() : 0;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Response receiver: a requested long hold-off wins, then a running
   // stall, then a fresh random stall; otherwise accept.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_holds_done != long_hold_requests) begin
         long_holds_done = long_holds_done + 1;
         stall_left      = LONG_HOLD - 1;
         rsp_bus.ready   <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left    = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
         stall_left    = idle_length() - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: sample both channels at the rising edge. Predict letters for
   // every request transfer, then check each response transfer against the
   // oldest letter still owed.
   always @(posedge clock) begin
      letter_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            spell_roman(req_bus.value);
            values_taken = values_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_letters.size() == 0) begin
               $error("response transfer with no letter owed: symbol %h last %b oor %b",
                      rsp_bus.symbol, rsp_bus.last, rsp_bus.out_of_range);
               failures = failures + 1;
            end else begin
               want = expected_letters.pop_front();
               if (rsp_bus.symbol !== want.symbol) begin
                  $error("symbol: expected %h, got %h", want.symbol, rsp_bus.symbol);
                  failures = failures + 1;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_bus.last);
                  failures = failures + 1;
               end
               if (rsp_bus.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %b, got %b",
                         want.out_of_range, rsp_bus.out_of_range);
                  failures = failures + 1;
               end
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_integer_to_roman_encoder failed");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned n;
      req_bus.valid      = 1'b0;
      req_bus.value      = '0;
      rsp_bus.ready      = 1'b0;
      reset              = 1'b1;
      req_fired          = 1'b0;
      gap_left           = 0;
      stall_left         = 0;
      tx_gaps_on         = 1'b0;
      rx_stalls_on       = 1'b0;
      long_hold_requests = 0;
      long_holds_done    = 0;
      values_queued      = 0;
      values_taken       = 0;
      failures           = 0;
      quiet_cycles       = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: range ends, out-of-range values, all-ones and single high
      // bit, every subtractive pair, every five-letter, pure thousands, and
      // the longest run.
      queue_value(12'd1);
      queue_value(12'd3999);
      queue_value(12'd3888);
      queue_value(12'd0);
      queue_value(12'd4000);
      queue_value(12'd4095);
      queue_value(12'd2048);
      queue_value(12'd4);
      queue_value(12'd9);
      queue_value(12'd40);
      queue_value(12'd90);
      queue_value(12'd400);
      queue_value(12'd900);
      queue_value(12'd5);
      queue_value(12'd50);
      queue_value(12'd500);
      queue_value(12'd1000);
      queue_value(12'd2000);
      queue_value(12'd3000);
      queue_value(12'd1994);
      queue_value(12'd444);
      queue_value(12'd999);
      queue_value(12'd14);
      drain();

      // Random with idling on both sides.
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      for (n = 0; n < 90; n++) begin
         queue_value(random_value());
      end
      drain();

      // Back-to-back stretch: no gaps, no stalls.
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      for (n = 0; n < 50; n++) begin
         queue_value(random_value());
      end
      drain();

      // Back-pressure: hold the response side off for a long stretch while
      // long values keep coming, so the block fills and stalls its input.
      long_hold_requests = long_hold_requests + 1;
      for (n = 0; n < 16; n++) begin
         queue_value(VALUE_W'($urandom_range(3000, MAX_VALUE)));
      end
      drain();

      // Random with sender gaps and receiver stalls again.
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      for (n = 0; n < 40; n++) begin
         queue_value(random_value());
      end
      drain();

      // Let any stray response show up before judging.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_letters.size() != 0) begin
         $error("%0d letters never arrived", expected_letters.size());
         failures = failures + 1;
      end
      if (failures == 0) begin
         $display("tb_integer_to_roman_encoder passed");
      end else begin
         $display("tb_integer_to_roman_encoder failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/rie_pkg.sv
hdl/rie_if.sv
hdl/rie_queue.sv
hdl/rie_front.sv
hdl/rie_back.sv
hdl/integer_to_roman_encoder.sv
hdl/rie_checker.sv
sim/tb_integer_to_roman_encoder.sv
